### sv/u8u16_pkg.sv
// shared types and constants of the utf-8 to utf-16 transcoder
package u8u16_pkg;

  localparam logic [15:0] SUBST_UNIT = 16'hFFFD;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;
  localparam int unsigned MAX_RES    = 4;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD   = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] ST_RANGE      = 2'd3;

  typedef struct packed {
    logic [1:0]  exp;     // continuations expected, 0 = no sequence open
    logic [1:0]  seen;    // continuations taken so far
    logic [20:0] gath;    // gathered code point bits
    logic        halted;  // swallowing up to the end of the string
  } dec_state_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        present;
    logic [1:0]  status;
    logic        done;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [2:0]            cnt;
  } res_list_t;

endpackage

### sv/utf8_to_utf16_transcoder.sv
// top level of the streaming utf-8 to utf-16 transcoder
//
// s_axis carries one utf-8 byte per item in tdata[7:0]; tlast marks the final
// byte of a string. m_axis gives one result per item: tdata holds the utf-16
// code unit and the run_last flag, tuser the unit_present flag and status,
// tlast marks the final result of a string.
// cfg_we_i / cfg_wdata_i write check_mode; only while the block is idle.
// A byte is accepted into an input register, decoded from there by short
// combinational logic into up to four results, and those land in a result
// buffer that drains one result per cycle while the receiver is ready.
// Throughput is one byte per cycle as long as each byte gives at most one
// result and the receiver is ready; a byte that gives more results holds
// the decoder while its results drain from the buffer. Swallowed bytes in
// check mode give no result and pass at one per cycle once the buffer is empty.
// When the receiver stalls, the buffer holds, then the input register
// fills and s_axis_tready_o drops.
// Reset clears the decode state, check_mode and all valid flags; no
// clearing pass is needed.
module utf8_to_utf16_transcoder import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // check_mode
  // byte input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_string
  // unit output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] code_unit, [16] run_last, rest zero
  output logic [2:0]  m_axis_tuser_o,   // [0] unit_present, [2:1] status
  output logic        m_axis_tlast_o    // string_done
);

  logic        check_mode_q;
  dec_state_t  st_q, st_d;

  // input register
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_eos_q;

  // result buffer
  result_t [MAX_RES-1:0] buf_q;
  logic [2:0]  rem_q;
  logic [1:0]  idx_q;

  res_list_t   list;
  result_t     cur;
  logic        out_take;
  logic        buf_free;
  logic        adv;

  u8u16_decode u_decode (
    .byte_i       (s1_byte_q),
    .eos_i        (s1_eos_q),
    .check_mode_i (check_mode_q),
    .st_i         (st_q),
    .st_o         (st_d),
    .list_o       (list)
  );

  assign out_take = m_axis_tvalid_o && m_axis_tready_i;
  // buffer can take the next byte's results this cycle
  assign buf_free = (rem_q == 3'd0) || ((rem_q == 3'd1) && m_axis_tready_i);
  assign adv      = s1_valid_q && buf_free;
  assign s_axis_tready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      check_mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_byte_q <= s_axis_tdata_i;
      s1_eos_q  <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      rem_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (adv) begin
      st_q  <= st_d;
      rem_q <= list.cnt;
      idx_q <= 2'd0;
    end else if (out_take) begin
      rem_q <= rem_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      buf_q <= list.res;
    end
  end

  assign cur             = buf_q[idx_q];
  assign m_axis_tvalid_o = (rem_q != 3'd0);
  assign m_axis_tdata_o  = {7'd0, (rem_q == 3'd1), cur.unit};
  assign m_axis_tuser_o  = {cur.status, cur.present};
  assign m_axis_tlast_o  = cur.done;

`ifndef SYNTHESIS
  // a status-only report always closes its byte and its string
  a_report_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tlast_o && m_axis_tdata_o[16]))
    else $error("status-only result not final");

  // swallowed bytes give no results
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && st_q.halted) |-> (list.cnt == 3'd0))
    else $error("result from a swallowed byte");

  // read position never runs past the buffer
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != 3'd0) |-> (({1'b0, idx_q} + rem_q) <= 3'(MAX_RES)))
    else $error("result buffer overrun");
`endif

endmodule

### sv/u8u16_decode.sv
// combinational decode of one byte into up to four utf-16 results
module u8u16_decode import u8u16_pkg::*; (
  input  logic [7:0]  byte_i,
  input  logic        eos_i,
  input  logic        check_mode_i,
  input  dec_state_t  st_i,
  output dec_state_t  st_o,
  output res_list_t   list_o
);

  logic        cont;
  logic [1:0]  ns;
  logic [20:0] newg;
  logic [19:0] v;
  logic        fail_a;
  logic [1:0]  taken_a;
  logic        stopped;
  logic        relead;
  res_list_t   l;
  dec_state_t  nx;

  function automatic res_list_t put(res_list_t li, logic [15:0] unit, logic present,
                                    logic [1:0] status, logic done);
    res_list_t lo;
    lo = li;
    if (lo.cnt < 3'(MAX_RES)) begin
      lo.res[lo.cnt[1:0]] = '{unit: unit, present: present, status: status, done: done};
      lo.cnt = lo.cnt + 3'd1;
    end
    return lo;
  endfunction

  assign cont = (byte_i[7:6] == 2'b10);
  assign ns   = st_i.seen + 2'd1;
  assign newg = {st_i.gath[14:0], byte_i[5:0]};
  assign v    = newg[19:0] - 20'h10000;

  always_comb begin
    l       = '0;
    nx      = st_i;
    stopped = 1'b0;
    relead  = 1'b1;
    fail_a  = 1'b0;
    taken_a = st_i.seen;
    if (st_i.halted) begin
      relead = 1'b0;
      if (eos_i) nx.halted = 1'b0;
    end else begin
      // sequence in progress
      if (st_i.exp != 2'd0) begin
        if (cont) begin
          relead  = 1'b0;
          nx.gath = newg;
          nx.seen = ns;
          if (ns == st_i.exp) begin
            nx.exp  = 2'd0;
            nx.seen = 2'd0;
            nx.gath = '0;
            if (newg[20] && (newg[19:16] != 4'd0)) begin
              if (check_mode_i) begin
                l       = put(l, 16'd0, 1'b0, ST_RANGE, 1'b1);
                stopped = 1'b1;
              end else begin
                l = put(l, SUBST_UNIT, 1'b1, ST_RANGE, 1'b0);
              end
            end else if (newg[20:16] == 5'd0) begin
              l = put(l, newg[15:0], 1'b1, ST_OK, 1'b0);
            end else begin
              l = put(l, HI_SURR | {6'd0, v[19:10]}, 1'b1, ST_OK, 1'b0);
              l = put(l, LO_SURR | {6'd0, v[9:0]}, 1'b1, ST_OK, 1'b0);
            end
          end else if (eos_i) begin
            fail_a  = 1'b1;
            taken_a = ns;
          end
        end else begin
          fail_a = 1'b1;
        end
      end
      // broken sequence
      if (fail_a) begin
        nx.exp  = 2'd0;
        nx.seen = 2'd0;
        nx.gath = '0;
        if (check_mode_i) begin
          l       = put(l, 16'd0, 1'b0, ST_INCOMPLETE, 1'b1);
          stopped = 1'b1;
        end else begin
          l = put(l, SUBST_UNIT, 1'b1, ST_INCOMPLETE, 1'b0);
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < taken_a) l = put(l, SUBST_UNIT, 1'b1, ST_BAD_LEAD, 1'b0);
          end
        end
      end
      // byte as a lead
      if (relead && !stopped) begin
        case (byte_i) inside
          [8'h00:8'h7F]: l = put(l, {8'd0, byte_i}, 1'b1, ST_OK, 1'b0);
          [8'hC0:8'hDF]: begin
            nx.exp  = 2'd1;
            nx.gath = {16'd0, byte_i[4:0]};
          end
          [8'hE0:8'hEF]: begin
            nx.exp  = 2'd2;
            nx.gath = {17'd0, byte_i[3:0]};
          end
          [8'hF0:8'hF7]: begin
            nx.exp  = 2'd3;
            nx.gath = {18'd0, byte_i[2:0]};
          end
          default: begin
            if (check_mode_i) begin
              l       = put(l, 16'd0, 1'b0, ST_BAD_LEAD, 1'b1);
              stopped = 1'b1;
            end else begin
              l = put(l, SUBST_UNIT, 1'b1, ST_BAD_LEAD, 1'b0);
            end
          end
        endcase
        if (nx.exp != 2'd0) begin
          nx.seen = 2'd0;
          if (eos_i) begin
            nx.exp  = 2'd0;
            nx.gath = '0;
            if (check_mode_i) begin
              l       = put(l, 16'd0, 1'b0, ST_INCOMPLETE, 1'b1);
              stopped = 1'b1;
            end else begin
              l = put(l, SUBST_UNIT, 1'b1, ST_INCOMPLETE, 1'b0);
            end
          end
        end
      end
      if (stopped) begin
        nx.exp    = 2'd0;
        nx.seen   = 2'd0;
        nx.gath   = '0;
        nx.halted = !eos_i;
      end
    end
    // end of string marks the last result of this byte
    if ((l.cnt != 3'd0) && eos_i) begin
      l.res[2'(l.cnt - 3'd1)].done = 1'b1;
    end
    list_o = l;
    st_o   = nx;
  end

endmodule

### bench/utf8_to_utf16_checker.sv
// checker for the utf-8 to utf-16 transcoder: predicts each result and compares it
`timescale 1ns / 1ps
module utf8_to_utf16_checker import u8u16_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [7:0]         s_axis_tdata_i,
  input  logic               s_axis_tlast_i,
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  input  logic [23:0]        m_axis_tdata_i,
  input  logic [2:0]         m_axis_tuser_i,
  input  logic               m_axis_tlast_i,
  output int unsigned        fail_count_o,
  output int unsigned        units_pending_o
);

  typedef struct packed {
    logic [15:0] unit;
    logic        present;
    logic [1:0]  status;
    logic        run_last;
    logic        done;
  } unit_rec_t;

  // own copy of the decoder state
  logic        check_mode;
  logic [1:0]  cont_needed;
  logic [1:0]  cont_taken;
  logic [20:0] cp_bits;
  logic        swallowing;
  logic        byte_stopped;

  unit_rec_t   units_due[$];
  unit_rec_t   byte_units[$];
  int unsigned fails = 0;

  assign fail_count_o = fails;

  task automatic drop_sequence();
    cont_needed = '0;
    cont_taken  = '0;
    cp_bits     = '0;
  endtask

  task automatic push_unit(input logic [15:0] unit, input logic present,
                           input logic [1:0] status, input logic done);
    unit_rec_t rec;
    rec.unit     = unit;
    rec.present  = present;
    rec.status   = status;
    rec.run_last = 1'b0;
    rec.done     = done;
    if (byte_units.size() < MAX_RES) byte_units.push_back(rec);
  endtask

  task automatic report_fault(input logic [1:0] status);
    if (check_mode) begin
      push_unit(16'h0000, 1'b0, status, 1'b1);
      drop_sequence();
      byte_stopped = 1'b1;
    end else begin
      push_unit(SUBST_UNIT, 1'b1, status, 1'b0);
    end
  endtask

  // one substitute for the lead, one per continuation already taken; in check mode a fault report instead
  task automatic abandon_sequence();
    logic [1:0] taken;
    taken = cont_taken;
    if (check_mode) begin
      report_fault(ST_INCOMPLETE);
    end else begin
      drop_sequence();
      push_unit(SUBST_UNIT, 1'b1, ST_INCOMPLETE, 1'b0);
      for (int i = 0; i < taken; i++) push_unit(SUBST_UNIT, 1'b1, ST_BAD_LEAD, 1'b0);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic        relead;
    logic        opened;
    logic [20:0] cp;
    logic [19:0] ofs;
    unit_rec_t   rec;
    byte_units.delete();
    byte_stopped = 1'b0;
    relead       = 1'b1;
    opened       = 1'b0;
    if (swallowing) begin
      if (eos) swallowing = 1'b0;
      return;
    end
    if (cont_needed != 0) begin
      if (b[7:6] == 2'b10) begin
        relead     = 1'b0;
        cp_bits    = {cp_bits[14:0], b[5:0]};
        cont_taken = cont_taken + 2'd1;
        if (cont_taken == cont_needed) begin
          cp = cp_bits;
          drop_sequence();
          if (cp > 21'h10FFFF) begin
            report_fault(ST_RANGE);
          end else if (cp < 21'h10000) begin
            push_unit(cp[15:0], 1'b1, ST_OK, 1'b0);
          end else begin
            ofs = 20'(cp - 21'h10000);
            push_unit(HI_SURR | {6'b0, ofs[19:10]}, 1'b1, ST_OK, 1'b0);
            push_unit(LO_SURR | {6'b0, ofs[9:0]}, 1'b1, ST_OK, 1'b0);
          end
        end else if (eos) begin
          abandon_sequence();
        end
      end else begin
        abandon_sequence();
      end
    end
    // a failing byte is decoded again as a new lead
    if (relead && !byte_stopped) begin
      if (!b[7]) begin
        push_unit({8'h00, b}, 1'b1, ST_OK, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        cont_needed = 2'd1;
        cp_bits     = {16'b0, b[4:0]};
        opened      = 1'b1;
      end else if (b[7:4] == 4'b1110) begin
        cont_needed = 2'd2;
        cp_bits     = {17'b0, b[3:0]};
        opened      = 1'b1;
      end else if (b[7:3] == 5'b11110) begin
        cont_needed = 2'd3;
        cp_bits     = {18'b0, b[2:0]};
        opened      = 1'b1;
      end else begin
        report_fault(ST_BAD_LEAD);
      end
      if (opened) begin
        cont_taken = '0;
        if (eos) abandon_sequence();
      end
    end
    if (byte_stopped) swallowing = !eos;
    if (byte_units.size() > 0) begin
      rec = byte_units.pop_back();
      rec.run_last = 1'b1;
      if (eos) rec.done = 1'b1;
      byte_units.push_back(rec);
    end
    foreach (byte_units[i]) units_due.push_back(byte_units[i]);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    unit_rec_t want;
    if (!rst_ni) begin
      check_mode   = 1'b0;
      swallowing   = 1'b0;
      byte_stopped = 1'b0;
      drop_sequence();
      units_due.delete();
      units_pending_o <= 0;
    end else begin
      if (cfg_we_i) check_mode = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_i) decode_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (units_due.size() == 0) begin
          $error("result with nothing expected: unit %h status %0d",
                 m_axis_tdata_i[15:0], m_axis_tuser_i[2:1]);
          fails++;
        end else begin
          want = units_due.pop_front();
          compare_field("code_unit", want.unit, m_axis_tdata_i[15:0]);
          compare_field("unit_present", {15'b0, want.present}, {15'b0, m_axis_tuser_i[0]});
          compare_field("status", {14'b0, want.status}, {14'b0, m_axis_tuser_i[2:1]});
          compare_field("run_last", {15'b0, want.run_last}, {15'b0, m_axis_tdata_i[16]});
          compare_field("string_done", {15'b0, want.done}, {15'b0, m_axis_tlast_i});
        end
      end
      units_pending_o <= units_due.size();
    end
  end

endmodule

### bench/utf8_to_utf16_transcoder_tb.sv
// testbench top of the utf-8 to utf-16 transcoder: stimulus, stalls and verdict
`timescale 1ns / 1ps
module utf8_to_utf16_transcoder_tb;

  // worst case is far below this: ~460 items, four results each, long stalls
  localparam time RUN_LIMIT = 5ms;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  int unsigned fail_count;
  int unsigned units_pending;

  // no idling on either side while set
  logic        calm = 1'b0;
  logic [7:0]  str_bytes[$];
  int unsigned random_items = 0;
  int unsigned phase_items = 0;
  int unsigned phase_len = 60;

  always #5ns clk = ~clk;

  utf8_to_utf16_transcoder u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  utf8_to_utf16_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .fail_count_o    (fail_count),
    .units_pending_o (units_pending)
  );

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // hold the item until the handshake, then maybe idle the channel for a while
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // directed string, first byte in the highest used byte of the word
  task automatic send_word(input logic [31:0] w, input int n);
    for (int i = n - 1; i >= 0; i--) send_byte(w[8*i +: 8], i == 0);
  endtask

  // write check_mode only once every expected result is out
  task automatic write_mode(input logic v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (units_pending != 0) @(posedge clk);
    // swallowed bytes leave no result behind, so give the pipeline time to empty
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // lead byte followed by a number of random continuation bytes
  task automatic push_seq(input logic [7:0] lead, input int conts);
    str_bytes.push_back(lead);
    repeat (conts) str_bytes.push_back({2'b10, 6'($urandom)});
  endtask

  // mostly well-formed characters with random content, the rest broken or noise
  task automatic build_string();
    int unsigned r;
    int unsigned len;
    str_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(0, 99);
      if (r < 28) begin
        str_bytes.push_back({1'b0, 7'($urandom)});
      end else if (r < 46) begin
        push_seq({3'b110, 5'($urandom)}, 1);
      end else if (r < 62) begin
        push_seq({4'b1110, 4'($urandom)}, 2);
      end else if (r < 78) begin
        // f0..f3 in range, f4 partly above the top code point, f5..f7 wholly above it
        push_seq({5'b11110, 3'($urandom_range(0, 7))}, 3);
      end else if (r < 90) begin
        len = $urandom_range(1, 3);
        push_seq(len == 1 ? {3'b110, 5'($urandom)} :
                 len == 2 ? {4'b1110, 4'($urandom)} : {5'b11110, 3'($urandom)},
                 $urandom_range(0, len - 1));
      end else begin
        str_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // receiver: bursts of ready with random stalls in between
  initial begin
    int unsigned stall;
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    #RUN_LIMIT;
    $display("utf8_to_utf16_transcoder test failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // substitute mode, straight after reset
    send_word(32'h0000C3A9, 3);   // lowest byte, two-byte char
    send_word(32'hF09F9880, 4);   // supplementary char, surrogate pair
    send_word(32'hF4908080, 4);   // above the top code point
    send_word(32'h0000C080, 2);   // overlong form passes as is
    send_word(32'h00EDA080, 3);   // encoded surrogate passes as is
    send_word(32'hF09F98FF, 4);   // broken by an invalid lead: four substitutes
    send_word(32'h00F09F98, 3);   // string ends on a continuation
    send_word(32'h000000C3, 1);   // string ends on a lead

    // check mode: first error reported, rest of the string swallowed
    write_mode(1'b1);
    send_word(32'h00008041, 2);   // stray continuation as lead, then swallow
    send_word(32'h000000C3, 1);   // failing byte carries the end flag
    write_mode(1'b0);

    // random strings, mode changes at random points, some inside a string
    while (random_items < 432) begin
      build_string();
      foreach (str_bytes[i]) begin
        send_byte(str_bytes[i], i == str_bytes.size() - 1);
        random_items++;
        phase_items++;
        if (phase_items >= phase_len) begin
          write_mode(1'($urandom_range(0, 1)));
          calm        = ($urandom_range(0, 3) == 0);
          phase_items = 0;
          phase_len   = $urandom_range(40, 120);
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (units_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("utf8_to_utf16_transcoder test passed");
    end else begin
      $display("utf8_to_utf16_transcoder test failed");
    end
    $finish;
  end

endmodule
